// ----- hw/rtl/cdecc_pkg.sv -----
// ----------------------------------------------------------------------------
// cdecc_pkg
// Shared types and constants for the CD sector EDC/ECC generator.
// ----------------------------------------------------------------------------
package cdecc_pkg;

	localparam int unsigned SECTOR_BYTES = 2352;
	localparam int unsigned ADDR_W       = $clog2(SECTOR_BYTES);
	localparam int unsigned DATA_W       = 8;

	// action codes
	localparam logic [1:0] ACT_WRITE = 2'd0;
	localparam logic [1:0] ACT_GEN   = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;

	// sector modes
	localparam logic [1:0] MODE_1   = 2'd1;
	localparam logic [1:0] MODE_2F1 = 2'd2;
	localparam logic [1:0] MODE_2F2 = 2'd3;

	// edc ranges (store address follows the last covered byte)
	localparam logic [ADDR_W-1:0] EDC_M1_FIRST  = 12'h000;
	localparam logic [ADDR_W-1:0] EDC_M1_LAST   = 12'h80F;
	localparam logic [ADDR_W-1:0] EDC_M2_FIRST  = 12'h010;
	localparam logic [ADDR_W-1:0] EDC_F1_LAST   = 12'h817;
	localparam logic [ADDR_W-1:0] EDC_F2_LAST   = 12'h92B;

	// ecc geometry
	localparam logic [ADDR_W-1:0] ECC_BASE   = 12'd12;
	localparam logic [6:0]        P_MAJORS   = 7'd86;
	localparam logic [6:0]        Q_MAJORS   = 7'd52;
	localparam logic [5:0]        P_MINORS   = 6'd24;
	localparam logic [5:0]        Q_MINORS   = 6'd43;
	localparam logic [ADDR_W-1:0] P_MULT     = 12'd2;
	localparam logic [ADDR_W-1:0] Q_MULT     = 12'd86;
	localparam logic [ADDR_W-1:0] P_INC      = 12'd86;
	localparam logic [ADDR_W-1:0] Q_INC      = 12'd88;
	localparam logic [ADDR_W-1:0] P_DEST     = 12'h81C;
	localparam logic [ADDR_W-1:0] Q_DEST     = 12'h8C8;
	localparam logic [ADDR_W-1:0] P_SPAN     = 12'd2064;
	localparam logic [ADDR_W-1:0] Q_SPAN     = 12'd2236;

	localparam logic [31:0] EDC_POLY = 32'hD801_8001;
	localparam logic [8:0]  GF_POLY  = 9'h11D;
	localparam logic [7:0]  GF_INV3  = 8'hF4;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_WAIT,
		ST_RESP,
		ST_EDC_RD,
		ST_EDC_END,
		ST_EDC_WR,
		ST_ZERO_WR,
		ST_ECC_RD,
		ST_ECC_END,
		ST_ECC_WR0,
		ST_ECC_WR1
	} state_t;

	typedef enum logic [2:0] {
		WS_INPUT,
		WS_CRC,
		WS_ZERO,
		WS_ECC_A,
		WS_ECC_B
	} wsel_t;

	typedef struct packed {
		logic       crc_clr;
		logic       crc_en;
		logic       ecc_clr;
		logic       ecc_en;
		logic       ecc_zero;
		logic       out_load;
		logic       out_zero;
		wsel_t      wsel;
		logic [1:0] crc_byte;
	} cmd_t;

endpackage

// ----- hw/rtl/cdecc_ram.sv -----
// ----------------------------------------------------------------------------
// cdecc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cdecc_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2352
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hw/rtl/cdecc_dp.sv -----
// ----------------------------------------------------------------------------
// cdecc_dp
// Datapath: crc-32 accumulator, gf(2^8) p/q parity accumulators,
// write data selection and read result register.
// ----------------------------------------------------------------------------
module cdecc_dp (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  cdecc_pkg::cmd_t                              cmd,
	input  logic [cdecc_pkg::DATA_W-1:0]                 byte_value,
	input  logic [cdecc_pkg::DATA_W-1:0]                 ram_rdata,
	output logic [cdecc_pkg::DATA_W-1:0]                 ram_wdata,
	output logic [cdecc_pkg::DATA_W-1:0]                 read_data
);

	function automatic logic [7:0] gf_dbl(input logic [7:0] x);
		gf_dbl = x[7] ? ((x << 1) ^ cdecc_pkg::GF_POLY[7:0]) : (x << 1);
	endfunction

	function automatic logic [7:0] gf_mul_inv3(input logic [7:0] x);
		logic [7:0] acc;
		logic [7:0] m;
		acc = '0;
		m   = x;
		for (int i = 0; i < 8; i++) begin
			if (cdecc_pkg::GF_INV3[i]) acc = acc ^ m;
			m = gf_dbl(m);
		end
		gf_mul_inv3 = acc;
	endfunction

	function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] d);
		logic [31:0] r;
		r = c ^ {24'd0, d};
		for (int i = 0; i < 8; i++) begin
			r = r[0] ? ((r >> 1) ^ cdecc_pkg::EDC_POLY) : (r >> 1);
		end
		crc_step = r;
	endfunction

	logic        crc_en_s1, ecc_en_s1, zero_s1, out_load_s1, out_zero_s1;
	logic [31:0] crc_q;
	logic [7:0]  a_q, b_q, rd_q;
	logic [7:0]  t_byte, a_fin;

	// align controls with registered ram read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_en_s1   <= 1'b0;
			ecc_en_s1   <= 1'b0;
			zero_s1     <= 1'b0;
			out_load_s1 <= 1'b0;
			out_zero_s1 <= 1'b0;
		end else begin
			crc_en_s1   <= cmd.crc_en;
			ecc_en_s1   <= cmd.ecc_en;
			zero_s1     <= cmd.ecc_zero;
			out_load_s1 <= cmd.out_load;
			out_zero_s1 <= cmd.out_zero;
		end
	end

	assign t_byte = zero_s1 ? 8'd0 : ram_rdata;
	assign a_fin  = gf_mul_inv3(gf_dbl(a_q) ^ b_q);

	// edc accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= '0;
		end else if (cmd.crc_clr) begin
			crc_q <= '0;
		end else if (crc_en_s1) begin
			crc_q <= crc_step(crc_q, ram_rdata);
		end
	end

	// parity accumulators
	always_ff @(posedge clk) begin
		if (cmd.ecc_clr) begin
			a_q <= '0;
			b_q <= '0;
		end else if (ecc_en_s1) begin
			a_q <= gf_dbl(a_q ^ t_byte);
			b_q <= b_q ^ t_byte;
		end
	end

	// read result register
	always_ff @(posedge clk) begin
		if (out_load_s1) begin
			rd_q <= out_zero_s1 ? 8'd0 : ram_rdata;
		end
	end
	assign read_data = rd_q;

	// write data select
	always_comb begin
		case (cmd.wsel)
			cdecc_pkg::WS_INPUT: ram_wdata = byte_value;
			cdecc_pkg::WS_CRC:   ram_wdata = crc_q[8*cmd.crc_byte +: 8];
			cdecc_pkg::WS_ZERO:  ram_wdata = 8'd0;
			cdecc_pkg::WS_ECC_A: ram_wdata = a_fin;
			cdecc_pkg::WS_ECC_B: ram_wdata = a_fin ^ b_q;
			default:             ram_wdata = 8'd0;
		endcase
	end

endmodule

// ----- hw/rtl/cdecc_ctrl.sv -----
// ----------------------------------------------------------------------------
// cdecc_ctrl
// Controller: handshakes, sector address sequencing for edc and p/q passes.
// ----------------------------------------------------------------------------
module cdecc_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     action,
	input  logic [cdecc_pkg::ADDR_W-1:0]   byte_index,
	input  logic [1:0]                     sector_mode,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           ram_we,
	output logic [cdecc_pkg::ADDR_W-1:0]   ram_waddr,
	output logic                           ram_re,
	output logic [cdecc_pkg::ADDR_W-1:0]   ram_raddr,
	output cdecc_pkg::cmd_t                cmd
);

	localparam int unsigned AW = cdecc_pkg::ADDR_W;

	cdecc_pkg::state_t state_q, state_d;
	logic [1:0]    mode_q, mode_d;
	logic [AW-1:0] addr_q, addr_d;
	logic [2:0]    k_q, k_d;
	logic          phase_q, phase_d;
	logic [6:0]    mj_q, mj_d;
	logic [5:0]    mn_q, mn_d;
	logic [AW-1:0] idx_q, idx_d;

	logic [AW-1:0] edc_last, mult, inc, dest, span, idx_inc, mj_start;
	logic [6:0]    majors, mj_nxt;
	logic [5:0]    minors;
	logic          in_range;

	assign in_range = byte_index < AW'(cdecc_pkg::SECTOR_BYTES);

	// pass geometry
	always_comb begin
		case (mode_q)
			cdecc_pkg::MODE_1:   edc_last = cdecc_pkg::EDC_M1_LAST;
			cdecc_pkg::MODE_2F1: edc_last = cdecc_pkg::EDC_F1_LAST;
			default:             edc_last = cdecc_pkg::EDC_F2_LAST;
		endcase
		majors = phase_q ? cdecc_pkg::Q_MAJORS : cdecc_pkg::P_MAJORS;
		minors = phase_q ? cdecc_pkg::Q_MINORS : cdecc_pkg::P_MINORS;
		mult   = phase_q ? cdecc_pkg::Q_MULT   : cdecc_pkg::P_MULT;
		inc    = phase_q ? cdecc_pkg::Q_INC    : cdecc_pkg::P_INC;
		dest   = phase_q ? cdecc_pkg::Q_DEST   : cdecc_pkg::P_DEST;
		span   = phase_q ? cdecc_pkg::Q_SPAN   : cdecc_pkg::P_SPAN;
		idx_inc  = idx_q + inc;
		mj_nxt   = mj_q + 7'd1;
		mj_start = AW'(AW'(mj_nxt[6:1]) * mult) + AW'(mj_nxt[0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cdecc_pkg::ST_IDLE;
			mode_q  <= '0;
			addr_q  <= '0;
			k_q     <= '0;
			phase_q <= 1'b0;
			mj_q    <= '0;
			mn_q    <= '0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			mode_q  <= mode_d;
			addr_q  <= addr_d;
			k_q     <= k_d;
			phase_q <= phase_d;
			mj_q    <= mj_d;
			mn_q    <= mn_d;
			idx_q   <= idx_d;
		end
	end

	assign in_stall  = state_q != cdecc_pkg::ST_IDLE;
	assign out_valid = state_q == cdecc_pkg::ST_RESP;

	// next state and commands
	always_comb begin
		state_d   = state_q;
		mode_d    = mode_q;
		addr_d    = addr_q;
		k_d       = k_q;
		phase_d   = phase_q;
		mj_d      = mj_q;
		mn_d      = mn_q;
		idx_d     = idx_q;
		cmd       = '0;
		cmd.wsel  = cdecc_pkg::WS_INPUT;
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_re    = 1'b0;
		ram_raddr = addr_q;
		case (state_q)
			cdecc_pkg::ST_IDLE: begin
				if (in_valid) begin
					case (action)
						cdecc_pkg::ACT_WRITE: begin
							ram_we    = in_range;
							ram_waddr = byte_index;
						end
						cdecc_pkg::ACT_READ: begin
							ram_re       = in_range;
							ram_raddr    = byte_index;
							cmd.out_load = 1'b1;
							cmd.out_zero = !in_range;
							state_d      = cdecc_pkg::ST_RD_WAIT;
						end
						cdecc_pkg::ACT_GEN: begin
							mode_d = sector_mode;
							if (sector_mode != 2'd0) begin
								cmd.crc_clr = 1'b1;
								addr_d  = (sector_mode == cdecc_pkg::MODE_1) ?
									cdecc_pkg::EDC_M1_FIRST : cdecc_pkg::EDC_M2_FIRST;
								state_d = cdecc_pkg::ST_EDC_RD;
							end
						end
						default: ;
					endcase
				end
			end
			cdecc_pkg::ST_RD_WAIT: state_d = cdecc_pkg::ST_RESP;
			cdecc_pkg::ST_RESP: begin
				if (!out_stall) state_d = cdecc_pkg::ST_IDLE;
			end
			// stream edc bytes
			cdecc_pkg::ST_EDC_RD: begin
				ram_re     = 1'b1;
				cmd.crc_en = 1'b1;
				addr_d     = addr_q + AW'(1);
				if (addr_q == edc_last) state_d = cdecc_pkg::ST_EDC_END;
			end
			cdecc_pkg::ST_EDC_END: begin
				k_d     = '0;
				state_d = cdecc_pkg::ST_EDC_WR;
			end
			// store edc little-endian
			cdecc_pkg::ST_EDC_WR: begin
				ram_we       = 1'b1;
				cmd.wsel     = cdecc_pkg::WS_CRC;
				cmd.crc_byte = k_q[1:0];
				addr_d       = addr_q + AW'(1);
				k_d          = k_q + 3'd1;
				if (k_q == 3'd3) begin
					k_d = '0;
					if (mode_q == cdecc_pkg::MODE_1) begin
						state_d = cdecc_pkg::ST_ZERO_WR;
					end else if (mode_q == cdecc_pkg::MODE_2F1) begin
						phase_d     = 1'b0;
						mj_d        = '0;
						mn_d        = '0;
						idx_d       = '0;
						cmd.ecc_clr = 1'b1;
						state_d     = cdecc_pkg::ST_ECC_RD;
					end else begin
						state_d = cdecc_pkg::ST_IDLE;
					end
				end
			end
			// clear the mode 1 reserved bytes
			cdecc_pkg::ST_ZERO_WR: begin
				ram_we   = 1'b1;
				cmd.wsel = cdecc_pkg::WS_ZERO;
				addr_d   = addr_q + AW'(1);
				k_d      = k_q + 3'd1;
				if (k_q == 3'd7) begin
					phase_d     = 1'b0;
					mj_d        = '0;
					mn_d        = '0;
					idx_d       = '0;
					cmd.ecc_clr = 1'b1;
					state_d     = cdecc_pkg::ST_ECC_RD;
				end
			end
			// walk one p column or q diagonal
			cdecc_pkg::ST_ECC_RD: begin
				ram_re       = 1'b1;
				ram_raddr    = cdecc_pkg::ECC_BASE + idx_q;
				cmd.ecc_en   = 1'b1;
				cmd.ecc_zero = (mode_q == cdecc_pkg::MODE_2F1) && (idx_q < AW'(4));
				idx_d        = (idx_inc >= span) ? (idx_inc - span) : idx_inc;
				mn_d         = mn_q + 6'd1;
				if (mn_q == minors - 6'd1) state_d = cdecc_pkg::ST_ECC_END;
			end
			cdecc_pkg::ST_ECC_END: state_d = cdecc_pkg::ST_ECC_WR0;
			cdecc_pkg::ST_ECC_WR0: begin
				ram_we    = 1'b1;
				ram_waddr = dest + AW'(mj_q);
				cmd.wsel  = cdecc_pkg::WS_ECC_A;
				state_d   = cdecc_pkg::ST_ECC_WR1;
			end
			cdecc_pkg::ST_ECC_WR1: begin
				ram_we      = 1'b1;
				ram_waddr   = dest + AW'(mj_q) + AW'(majors);
				cmd.wsel    = cdecc_pkg::WS_ECC_B;
				cmd.ecc_clr = 1'b1;
				mn_d        = '0;
				state_d     = cdecc_pkg::ST_ECC_RD;
				if (mj_q == majors - 7'd1) begin
					mj_d  = '0;
					idx_d = '0;
					if (phase_q) begin
						state_d = cdecc_pkg::ST_IDLE;
					end else begin
						phase_d = 1'b1;
					end
				end else begin
					mj_d  = mj_nxt;
					idx_d = mj_start;
				end
			end
			default: state_d = cdecc_pkg::ST_IDLE;
		endcase
	end

endmodule

// ----- hw/rtl/cd_sector_ecc_edc_generator_top.sv -----
// ----------------------------------------------------------------------------
// cd_sector_ecc_edc_generator_top
// Raw CD-ROM sector buffer with EDC and P/Q parity generation.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) carries one beat per command: write a
// byte, read a byte, or generate codes for sector_mode. Output channel
// (out_valid/out_stall) carries one read_data beat per read command.
// Back-to-back writes go at one beat per cycle while the block is idle.
// A read beat moves the controller through ST_RD_WAIT to ST_RESP, where
// out_valid is high, behind the registered read of the sector RAM and
// the read result register, and the block takes no new beat until the
// result is taken. Generation reads the sector RAM one byte per cycle
// while streaming EDC bytes, a P column or a Q diagonal: first the EDC,
// then P and Q except in mode 2 form 2; in_stall stays high.
// Reset clears the controller and the EDC register; the sector store holds
// nothing meaningful until written. While out_stall is high the result
// beat holds and in_stall stays high.
// ----------------------------------------------------------------------------
module cd_sector_ecc_edc_generator_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [11:0] byte_index,
	input  logic [7:0]  byte_value,
	input  logic [1:0]  sector_mode,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  read_data
);

	logic                                ram_we, ram_re;
	logic [cdecc_pkg::ADDR_W-1:0]        ram_waddr, ram_raddr;
	logic [cdecc_pkg::DATA_W-1:0]        ram_wdata, ram_rdata;
	cdecc_pkg::cmd_t                     cmd;

	// sector store
	cdecc_ram #(
		.WIDTH(cdecc_pkg::DATA_W),
		.DEPTH(cdecc_pkg::SECTOR_BYTES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// sequencing
	cdecc_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.byte_index  (byte_index),
		.sector_mode (sector_mode),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.ram_we      (ram_we),
		.ram_waddr   (ram_waddr),
		.ram_re      (ram_re),
		.ram_raddr   (ram_raddr),
		.cmd         (cmd)
	);

	// arithmetic
	cdecc_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.byte_value (byte_value),
		.ram_rdata  (ram_rdata),
		.ram_wdata  (ram_wdata),
		.read_data  (read_data)
	);

endmodule
